@@ rtl/smalu_pkg.sv @@
package smalu_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned UPC_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_POP  = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [ST_W-1:0] ST_DIVZERO   = 2'd3;

  // microprogram addresses
  localparam logic [UPC_W-1:0] U_IDLE = 5'd0;
  localparam logic [UPC_W-1:0] U_PUSH = 5'd1;
  localparam logic [UPC_W-1:0] U_POP0 = 5'd2;
  localparam logic [UPC_W-1:0] U_POP1 = 5'd3;
  localparam logic [UPC_W-1:0] U_AR0  = 5'd4;
  localparam logic [UPC_W-1:0] U_AR1  = 5'd5;
  localparam logic [UPC_W-1:0] U_AR2  = 5'd6;
  localparam logic [UPC_W-1:0] U_ALU  = 5'd7;
  localparam logic [UPC_W-1:0] U_WB   = 5'd8;
  localparam logic [UPC_W-1:0] U_DIV0 = 5'd9;
  localparam logic [UPC_W-1:0] U_DIV1 = 5'd10;
  localparam logic [UPC_W-1:0] U_DIV2 = 5'd11;
  localparam logic [UPC_W-1:0] U_OVF  = 5'd12;
  localparam logic [UPC_W-1:0] U_UND  = 5'd13;
  localparam logic [UPC_W-1:0] U_DZ   = 5'd14;
  localparam logic [UPC_W-1:0] U_NOP  = 5'd15;
  localparam logic [UPC_W-1:0] U_EMIT = 5'd16;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_DISPATCH,
    JC_ALUSEL,
    JC_LOOP,
    JC_EMIT
  } jump_e;

  typedef enum logic {
    RD_TOP,
    RD_NEXT
  } rd_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUSH,
    WR_RES
  } wr_e;

  typedef enum logic [2:0] {
    RES_KEEP,
    RES_VAL,
    RES_RDATA,
    RES_ALU,
    RES_QUO,
    RES_ZERO
  } res_e;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC
  } cnt_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_INIT,
    DIV_STEP
  } div_cmd_e;

  typedef struct packed {
    rd_e              rd;
    logic             ld_b;
    logic             ld_a;
    wr_e              wr;
    res_e             res;
    cnt_e             cnt;
    logic             st_ld;
    logic [ST_W-1:0]  st;
    div_cmd_e         div;
    jump_e            jc;
    logic [UPC_W-1:0] tgt;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = '{
    rd:    RD_TOP,
    ld_b:  1'b0,
    ld_a:  1'b0,
    wr:    WR_NONE,
    res:   RES_KEEP,
    cnt:   CNT_KEEP,
    st_ld: 1'b0,
    st:    ST_OK,
    div:   DIV_IDLE,
    jc:    JC_DISPATCH,
    tgt:   U_IDLE
  };

  // control store
  function automatic ctrl_t ucode(logic [UPC_W-1:0] addr);
    ctrl_t c;
    c = CTRL_IDLE;
    unique case (addr)
      U_IDLE: begin
        c.jc = JC_DISPATCH;
      end
      U_PUSH: begin
        c.wr = WR_PUSH; c.res = RES_VAL; c.cnt = CNT_INC;
        c.st_ld = 1'b1; c.st = ST_OK; c.jc = JC_GOTO; c.tgt = U_EMIT;
      end
      U_POP0: begin
        c.rd = RD_TOP; c.jc = JC_NEXT;
      end
      U_POP1: begin
        c.res = RES_RDATA; c.cnt = CNT_DEC;
        c.st_ld = 1'b1; c.st = ST_OK; c.jc = JC_GOTO; c.tgt = U_EMIT;
      end
      U_AR0: begin
        c.rd = RD_TOP; c.jc = JC_NEXT;
      end
      U_AR1: begin
        c.ld_b = 1'b1; c.rd = RD_NEXT; c.jc = JC_NEXT;
      end
      U_AR2: begin
        c.ld_a = 1'b1; c.jc = JC_ALUSEL;
      end
      U_ALU: begin
        c.res = RES_ALU; c.jc = JC_NEXT;
      end
      U_WB: begin
        c.wr = WR_RES; c.cnt = CNT_DEC;
        c.st_ld = 1'b1; c.st = ST_OK; c.jc = JC_GOTO; c.tgt = U_EMIT;
      end
      U_DIV0: begin
        c.div = DIV_INIT; c.jc = JC_NEXT;
      end
      U_DIV1: begin
        c.div = DIV_STEP; c.jc = JC_LOOP;
      end
      U_DIV2: begin
        c.res = RES_QUO; c.jc = JC_GOTO; c.tgt = U_WB;
      end
      U_OVF: begin
        c.res = RES_ZERO; c.st_ld = 1'b1; c.st = ST_OVERFLOW;
        c.jc = JC_GOTO; c.tgt = U_EMIT;
      end
      U_UND: begin
        c.res = RES_ZERO; c.st_ld = 1'b1; c.st = ST_UNDERFLOW;
        c.jc = JC_GOTO; c.tgt = U_EMIT;
      end
      U_DZ: begin
        c.res = RES_ZERO; c.st_ld = 1'b1; c.st = ST_DIVZERO;
        c.jc = JC_GOTO; c.tgt = U_EMIT;
      end
      U_NOP: begin
        c.res = RES_ZERO; c.st_ld = 1'b1; c.st = ST_OK;
        c.jc = JC_GOTO; c.tgt = U_EMIT;
      end
      U_EMIT: begin
        c.jc = JC_EMIT; c.tgt = U_IDLE;
      end
      default: begin
        c.jc = JC_GOTO; c.tgt = U_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

@@ rtl/smalu_in_if.sv @@
interface smalu_in_if import smalu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

@@ rtl/smalu_out_if.sv @@
interface smalu_out_if import smalu_pkg::*; #(
  parameter int unsigned DEPTH_W = 5
) ();
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] data;
  logic [DEPTH_W-1:0]       depth;

  modport source (output valid, output status, output data, output depth, input ready);
  modport sink (input valid, input status, input data, input depth, output ready);
endinterface

@@ rtl/smalu_div.sv @@
module smalu_div import smalu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_cmd_e          cmd_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic [DATA_W-1:0] quotient_o,
  output logic              last_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dsr_q, dsr_d;
  logic              neg_q, neg_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dsr_d = dsr_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    case (cmd_i)
      DIV_INIT: begin
        rem_d = '0;
        quo_d = dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
        dsr_d = divisor_i[DATA_W-1] ? (~divisor_i + 1'b1) : divisor_i;
        neg_d = dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
        cnt_d = CNT_W'(DATA_W - 1);
      end
      DIV_STEP: begin
        if (!diff[DATA_W]) begin
          rem_d = diff[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = shifted[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign last_o     = (cnt_q == '0);

endmodule

@@ rtl/stack_machine_alu_top.sv @@
// channel | dir | handshake     | payload
// req_i   | in  | valid / ready | operation, value
// rsp_o   | out | valid / ready | status, data, depth
//
// One request at a time, run by a microprogram sequencer; the result sits in
// an output register while the next request is taken.
// Divide runs the radix-2 divider loop, one quotient bit per step; a divide
// by zero skips the loop.
// Reset empties the stack at once; the stack memory itself is not cleared.
// A stalled response holds the sequencer in its emit step.
module stack_machine_alu_top import smalu_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  smalu_in_if.sink     req_i,
  smalu_out_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  logic [UPC_W-1:0]  upc_q, upc_d;
  ctrl_t             cw;
  logic [DW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]     top_w, next_w;
  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] a_q, b_q;
  logic [DATA_W-1:0] res_q, res_d;
  logic [ST_W-1:0]   st_q;
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [AW-1:0]     raddr, waddr;
  logic [DATA_W-1:0] wdata;
  logic              wr_en;
  logic [DATA_W-1:0] alu_w;
  logic [DATA_W-1:0] quo_w;
  logic              div_last;
  logic              fire;
  logic              slot_free;
  logic              emit;
  logic              out_valid_q;
  logic [ST_W-1:0]   out_st_q;
  logic [DATA_W-1:0] out_data_q;
  logic [DW-1:0]     out_depth_q;

  assign cw        = ucode(upc_q);
  assign req_i.ready = (upc_q == U_IDLE);
  assign fire      = req_i.valid && req_i.ready;
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign emit      = (cw.jc == JC_EMIT) && slot_free;

  assign top_w  = cnt_q - DW'(1);
  assign next_w = cnt_q - DW'(2);

  // sequencer
  always_comb begin
    upc_d = upc_q;
    unique case (cw.jc)
      JC_NEXT: upc_d = upc_q + 1'b1;
      JC_GOTO: upc_d = cw.tgt;
      JC_DISPATCH: begin
        if (fire) begin
          unique case (req_i.operation) inside
            OP_PUSH: upc_d = (cnt_q == DW'(STACK_DEPTH)) ? U_OVF : U_PUSH;
            OP_POP:  upc_d = (cnt_q == '0) ? U_UND : U_POP0;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                     upc_d = (cnt_q < DW'(2)) ? U_UND : U_AR0;
            default: upc_d = U_NOP;
          endcase
        end
      end
      JC_ALUSEL: begin
        if (op_q == OP_DIV) begin
          upc_d = (b_q == '0) ? U_DZ : U_DIV0;
        end else begin
          upc_d = U_ALU;
        end
      end
      JC_LOOP: upc_d = div_last ? upc_q + 1'b1 : upc_q;
      JC_EMIT: upc_d = slot_free ? cw.tgt : upc_q;
      default: upc_d = U_IDLE;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_ADD:  alu_w = a_q + b_q;
      OP_SUB:  alu_w = a_q - b_q;
      default: alu_w = a_q * b_q;
    endcase
  end

  always_comb begin
    case (cw.res)
      RES_VAL:   res_d = val_q;
      RES_RDATA: res_d = rdata_q;
      RES_ALU:   res_d = alu_w;
      RES_QUO:   res_d = quo_w;
      RES_ZERO:  res_d = '0;
      default:   res_d = res_q;
    endcase
  end

  always_comb begin
    case (cw.cnt)
      CNT_INC: cnt_d = cnt_q + 1'b1;
      CNT_DEC: cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  assign raddr = (cw.rd == RD_NEXT) ? next_w[AW-1:0] : top_w[AW-1:0];
  assign wr_en = (cw.wr != WR_NONE);
  assign waddr = (cw.wr == WR_PUSH) ? cnt_q[AW-1:0] : next_w[AW-1:0];
  assign wdata = (cw.wr == WR_PUSH) ? val_q : res_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  smalu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cw.div),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .quotient_o (quo_w),
    .last_o     (div_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      cnt_q <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      op_q  <= req_i.operation;
      val_q <= req_i.value;
    end
    if (cw.ld_a) begin
      a_q <= rdata_q;
    end
    if (cw.ld_b) begin
      b_q <= rdata_q;
    end
    if (cw.st_ld) begin
      st_q <= cw.st;
    end
    res_q <= res_d;
    if (emit) begin
      out_st_q    <= st_q;
      out_data_q  <= res_q;
      out_depth_q <= cnt_q;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_st_q;
  assign rsp_o.data   = out_data_q;
  assign rsp_o.depth  = out_depth_q;

endmodule
